[hw/rtl/sfr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfr_pkg: shared types and constants for the stuffed frame receiver
// Byte codes, check status codes and the result queue entry.
// ----------------------------------------------------------------------------
package sfr_pkg;

    localparam int MAX_CHUNK = 1024;
    localparam int CNT_W     = 11;
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    localparam logic [7:0] FLAG_BYTE   = 8'h7E;
    localparam logic [7:0] ESC_BYTE    = 8'h7D;
    localparam logic [7:0] ESC_FLAG    = 8'h5E;
    localparam logic [7:0] ESC_ESC     = 8'h5D;
    localparam logic [7:0] REPLY_ADDR  = 8'h03;
    localparam logic [7:0] SEQ0_BYTE   = 8'h00;
    localparam logic [7:0] CTRL_RR0    = 8'hAA;
    localparam logic [7:0] CTRL_RR1    = 8'hAB;
    localparam logic [7:0] CTRL_REJ0   = 8'h54;
    localparam logic [7:0] CTRL_REJ1   = 8'h55;
    localparam logic [7:0] ADDR_RESET  = 8'h03;

    localparam logic [CNT_W-1:0] MIN_LEN = CNT_W'(6);
    // clean bytes at this position and later push a delayed payload byte
    localparam logic [CNT_W-1:0] PAY_POS = CNT_W'(6);

    typedef enum logic [2:0] {
        ST_ACCEPTED = 3'd0,
        ST_SHORT    = 3'd1,
        ST_BAD_FLAG = 3'd2,
        ST_BAD_ADDR = 3'd3,
        ST_BAD_BCC  = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        BEAT_FLAG0 = 3'd0,
        BEAT_ADDR  = 3'd1,
        BEAT_CTRL  = 3'd2,
        BEAT_BCC1  = 3'd3,
        BEAT_FLAG1 = 3'd4
    } t_beat;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    // one queue entry: a payload byte, or a reply frame given by its ctrl byte
    typedef struct packed {
        logic       reply;
        logic [7:0] data;
        t_status    status;
    } t_entry;

endpackage

[hw/rtl/stuffed_frame_receiver.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stuffed_frame_receiver: destuffs one chunk, forwards payload, answers RR/REJ
// Results enter the four-entry queue as the input words that yield them are
// taken. Throughput: one input word per cycle while o_stall is low; a chunk end
// adds a five-word reply played out at one word per cycle while i_stall is low.
// Reset (synchronous, active low) clears chunk state, the queue and sets the
// expected address to 0x03.
// ----------------------------------------------------------------------------
module stuffed_frame_receiver (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_data,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_rx_byte,
    input  logic       i_chunk_end,
    output logic       o_valid,
    input  logic       i_stall,
    output logic       o_out_kind,
    output logic [7:0] o_out_byte,
    output logic [2:0] o_frame_status,
    output logic       o_last_out
);

    localparam int CW = sfr_pkg::CNT_W;
    localparam int PW = sfr_pkg::QPTR_W;

    logic [7:0]    r_exp_addr;
    logic          r_esc;
    logic [CW-1:0] r_raw_cnt,  n_raw_cnt;
    logic [CW-1:0] r_clean_cnt, n_clean_cnt;
    logic [7:0]    r_dly0, n_dly0;
    logic [7:0]    r_dly1, n_dly1;
    logic [7:0]    r_parity, n_parity;
    logic [7:0]    r_first, n_first;
    logic [7:0]    r_addr, n_addr;
    logic          r_seq, n_seq;
    logic          n_esc;

    sfr_pkg::t_entry r_queue [sfr_pkg::QDEPTH];
    logic [PW-1:0]   r_wr_ptr, r_rd_ptr;
    logic [PW:0]     r_count;
    sfr_pkg::t_beat  r_beat;

    logic            in_acc, out_acc, pop;
    logic            take, have, push_pay;
    logic [7:0]      clean;
    sfr_pkg::t_status status;
    logic            seq;
    logic [7:0]      ctrl;
    sfr_pkg::t_entry pay_entry, rep_entry, head;
    logic [1:0]      n_push;

    assign in_acc  = i_valid && !o_stall;
    assign o_stall = (r_count > (PW+1)'(sfr_pkg::QDEPTH - 2));

    // per-word destuff, delay line and frame checks
    always_comb begin
        take = (32'(r_raw_cnt) < sfr_pkg::MAX_CHUNK);
        n_raw_cnt = (r_raw_cnt < sfr_pkg::CNT_MAX) ? r_raw_cnt + CW'(1) : r_raw_cnt;
        n_esc = r_esc;
        have  = 1'b0;
        clean = i_rx_byte;
        if (take) begin
            if (r_esc) begin
                n_esc = 1'b0;
                have  = 1'b1;
                if (i_rx_byte == sfr_pkg::ESC_FLAG)
                    clean = sfr_pkg::FLAG_BYTE;
                else if (i_rx_byte == sfr_pkg::ESC_ESC)
                    clean = sfr_pkg::ESC_BYTE;
            end else if (i_rx_byte == sfr_pkg::ESC_BYTE) begin
                n_esc = 1'b1;
            end else begin
                have = 1'b1;
            end
        end

        n_first     = r_first;
        n_addr      = r_addr;
        n_seq       = r_seq;
        n_dly0      = r_dly0;
        n_dly1      = r_dly1;
        n_parity    = r_parity;
        n_clean_cnt = r_clean_cnt;
        push_pay    = 1'b0;
        if (have) begin
            if (r_clean_cnt == CW'(0))
                n_first = clean;
            else if (r_clean_cnt == CW'(1))
                n_addr = clean;
            else if (r_clean_cnt == CW'(2))
                n_seq = (clean != sfr_pkg::SEQ0_BYTE);
            if (r_clean_cnt >= sfr_pkg::PAY_POS) begin
                push_pay = 1'b1;
                n_parity = r_parity ^ r_dly0;
            end
            n_dly0 = r_dly1;
            n_dly1 = clean;
            if (r_clean_cnt < sfr_pkg::CNT_MAX)
                n_clean_cnt = r_clean_cnt + CW'(1);
        end

        seq = n_seq;
        if (n_raw_cnt < sfr_pkg::MIN_LEN || n_clean_cnt < sfr_pkg::MIN_LEN) begin
            status = sfr_pkg::ST_SHORT;
            seq    = 1'b0;
        end else if (n_first != sfr_pkg::FLAG_BYTE || n_dly1 != sfr_pkg::FLAG_BYTE) begin
            status = sfr_pkg::ST_BAD_FLAG;
        end else if (n_addr != r_exp_addr) begin
            status = sfr_pkg::ST_BAD_ADDR;
        end else if (n_dly0 != n_parity) begin
            status = sfr_pkg::ST_BAD_BCC;
        end else begin
            status = sfr_pkg::ST_ACCEPTED;
        end
        if (status == sfr_pkg::ST_ACCEPTED)
            ctrl = seq ? sfr_pkg::CTRL_RR1 : sfr_pkg::CTRL_RR0;
        else
            ctrl = seq ? sfr_pkg::CTRL_REJ1 : sfr_pkg::CTRL_REJ0;

        pay_entry.reply  = 1'b0;
        pay_entry.data   = r_dly0;
        pay_entry.status = sfr_pkg::ST_ACCEPTED;
        rep_entry.reply  = 1'b1;
        rep_entry.data   = ctrl;
        rep_entry.status = status;

        n_push = 2'(in_acc && push_pay) + 2'(in_acc && i_chunk_end);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_addr <= sfr_pkg::ADDR_RESET;
        end else if (i_cfg_we) begin
            r_exp_addr <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (in_acc && i_chunk_end)) begin
            r_esc       <= 1'b0;
            r_raw_cnt   <= '0;
            r_clean_cnt <= '0;
            r_dly0      <= '0;
            r_dly1      <= '0;
            r_parity    <= '0;
            r_first     <= '0;
            r_addr      <= '0;
            r_seq       <= 1'b0;
        end else if (in_acc) begin
            r_esc       <= n_esc;
            r_raw_cnt   <= n_raw_cnt;
            r_clean_cnt <= n_clean_cnt;
            r_dly0      <= n_dly0;
            r_dly1      <= n_dly1;
            r_parity    <= n_parity;
            r_first     <= n_first;
            r_addr      <= n_addr;
            r_seq       <= n_seq;
        end
    end

    // queue storage: payload goes first, the reply right behind it
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            if (push_pay) begin
                r_queue[r_wr_ptr] <= pay_entry;
                if (i_chunk_end)
                    r_queue[r_wr_ptr + PW'(1)] <= rep_entry;
            end else if (i_chunk_end) begin
                r_queue[r_wr_ptr] <= rep_entry;
            end
        end
    end

    // output side: a reply entry expands into five words
    assign head    = r_queue[r_rd_ptr];
    assign o_valid = (r_count != '0);
    assign out_acc = o_valid && !i_stall;
    assign pop     = out_acc && (!head.reply || r_beat == sfr_pkg::BEAT_FLAG1);

    always_comb begin
        o_out_kind     = head.reply;
        o_frame_status = head.status;
        o_last_out     = head.reply && (r_beat == sfr_pkg::BEAT_FLAG1);
        o_out_byte     = head.data;
        if (head.reply) begin
            unique case (r_beat)
                sfr_pkg::BEAT_FLAG0: o_out_byte = sfr_pkg::FLAG_BYTE;
                sfr_pkg::BEAT_ADDR:  o_out_byte = sfr_pkg::REPLY_ADDR;
                sfr_pkg::BEAT_CTRL:  o_out_byte = head.data;
                sfr_pkg::BEAT_BCC1:  o_out_byte = sfr_pkg::REPLY_ADDR ^ head.data;
                sfr_pkg::BEAT_FLAG1: o_out_byte = sfr_pkg::FLAG_BYTE;
                default:             o_out_byte = sfr_pkg::FLAG_BYTE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
            r_beat   <= sfr_pkg::BEAT_FLAG0;
        end else begin
            r_wr_ptr <= r_wr_ptr + PW'(n_push);
            if (pop)
                r_rd_ptr <= r_rd_ptr + PW'(1);
            r_count <= r_count + (PW+1)'(n_push) - (PW+1)'(pop);
            if (out_acc && head.reply) begin
                if (r_beat == sfr_pkg::BEAT_FLAG1)
                    r_beat <= sfr_pkg::BEAT_FLAG0;
                else
                    r_beat <= sfr_pkg::t_beat'(r_beat + 3'd1);
            end
        end
    end

endmodule

[test/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for stuffed_frame_receiver
// Feeds byte-stuffed frame chunks (good frames, damaged frames and noise)
// under random idle and stall, predicts every payload and reply word
// in-bench, and compares each output word in order. The expected address is
// reprogrammed between phases.
// ----------------------------------------------------------------------------
module tb;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 200;
    localparam int PHASES       = 6;
    localparam int PHASE_WORDS  = 55;

    typedef enum int {
        F_NONE, F_ADDR, F_HEAD, F_TAIL, F_BCC, F_TRUNC, F_NOISE, F_DANGLE
    } t_flaw;

    typedef struct packed {
        logic [7:0] b;
        logic       fin;
    } t_raw_word;

    typedef struct packed {
        logic             kind;
        logic [7:0]       data;
        sfr_pkg::t_status status;
        logic             last;
    } t_out_word;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_cfg_we = 1'b0;
    logic [7:0] i_cfg_data = 8'h00;
    logic       i_valid = 1'b0;
    logic       o_stall;
    logic [7:0] i_rx_byte = 8'h00;
    logic       i_chunk_end = 1'b0;
    logic       o_valid;
    logic       i_stall = 1'b0;
    logic       o_out_kind;
    logic [7:0] o_out_byte;
    logic [2:0] o_frame_status;
    logic       o_last_out;

    stuffed_frame_receiver dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_rx_byte     (i_rx_byte),
        .i_chunk_end   (i_chunk_end),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_out_kind    (o_out_kind),
        .o_out_byte    (o_out_byte),
        .o_frame_status(o_frame_status),
        .o_last_out    (o_last_out)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // receiver model state
    logic [7:0]  addr_cfg;
    logic        esc_open;
    logic [10:0] raw_cnt;
    logic [10:0] clean_cnt;
    logic [7:0]  dly_old;
    logic [7:0]  dly_new;
    logic [7:0]  bcc_run;
    logic [7:0]  flag_head;
    logic [7:0]  addr_got;
    logic        seq_sel;

    t_raw_word tx_queue[$];
    t_out_word rx_out_words[$];
    t_raw_word tx_next;
    t_out_word rx_head;

    int words_queued = 0;
    int words_taken = 0;
    int words_checked = 0;
    int chunks_closed = 0;
    int mismatches = 0;
    int cycles = 0;
    int status_count[5] = '{0, 0, 0, 0, 0};
    int tx_wait = 0;
    int rx_wait = 0;
    int hold_left = 0;
    int hold_asked = 0;
    int hold_given = 0;
    logic tx_idle = 1'b1;
    logic rx_idle = 1'b1;

    function automatic int draw_gap(input logic busy);
        return busy ? int'($urandom_range(0, 3)) : 0;
    endfunction

    // random byte, biased toward the flag and escape codes
    function automatic logic [7:0] rand_byte();
        case ($urandom_range(0, 11))
            0: return sfr_pkg::FLAG_BYTE;
            1: return sfr_pkg::ESC_BYTE;
            2: return sfr_pkg::ESC_FLAG;
            3: return sfr_pkg::ESC_ESC;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic clear_frame_state();
        esc_open  = 1'b0;
        raw_cnt   = '0;
        clean_cnt = '0;
        dly_old   = 8'h00;
        dly_new   = 8'h00;
        bcc_run   = 8'h00;
        flag_head = 8'h00;
        addr_got  = 8'h00;
        seq_sel   = 1'b0;
    endtask

    task automatic push_word(input logic kind, input logic [7:0] data,
                             input sfr_pkg::t_status st, input logic last);
        rx_out_words.push_back({kind, data, st, last});
    endtask

    // destuff one raw byte; queue the payload word and, at chunk end, the reply
    task automatic destuff_byte(input logic [7:0] rb, input logic fin);
        logic             take;
        logic             have;
        logic [7:0]       cb;
        logic [7:0]       ctrl;
        logic             sq;
        sfr_pkg::t_status st;
        take = raw_cnt < sfr_pkg::MAX_CHUNK;
        if (raw_cnt != sfr_pkg::CNT_MAX) raw_cnt++;
        have = 1'b0;
        cb = rb;
        if (take) begin
            if (esc_open) begin
                esc_open = 1'b0;
                have = 1'b1;
                if (rb == sfr_pkg::ESC_FLAG) cb = sfr_pkg::FLAG_BYTE;
                else if (rb == sfr_pkg::ESC_ESC) cb = sfr_pkg::ESC_BYTE;
            end else if (rb == sfr_pkg::ESC_BYTE) begin
                esc_open = 1'b1;
            end else begin
                have = 1'b1;
            end
        end
        if (have) begin
            if (clean_cnt == 0) flag_head = cb;
            else if (clean_cnt == 1) addr_got = cb;
            else if (clean_cnt == 2) seq_sel = (cb != sfr_pkg::SEQ0_BYTE);
            if (clean_cnt >= sfr_pkg::PAY_POS) begin
                bcc_run ^= dly_old;
                push_word(1'b0, dly_old, sfr_pkg::ST_ACCEPTED, 1'b0);
            end
            dly_old = dly_new;
            dly_new = cb;
            if (clean_cnt != sfr_pkg::CNT_MAX) clean_cnt++;
        end
        if (fin) begin
            sq = seq_sel;
            if (raw_cnt < sfr_pkg::MIN_LEN || clean_cnt < sfr_pkg::MIN_LEN) begin
                st = sfr_pkg::ST_SHORT;
                sq = 1'b0;
            end else if (flag_head != sfr_pkg::FLAG_BYTE || dly_new != sfr_pkg::FLAG_BYTE) begin
                st = sfr_pkg::ST_BAD_FLAG;
            end else if (addr_got != addr_cfg) begin
                st = sfr_pkg::ST_BAD_ADDR;
            end else if (dly_old != bcc_run) begin
                st = sfr_pkg::ST_BAD_BCC;
            end else begin
                st = sfr_pkg::ST_ACCEPTED;
            end
            if (st == sfr_pkg::ST_ACCEPTED) ctrl = sq ? sfr_pkg::CTRL_RR1 : sfr_pkg::CTRL_RR0;
            else ctrl = sq ? sfr_pkg::CTRL_REJ1 : sfr_pkg::CTRL_REJ0;
            push_word(1'b1, sfr_pkg::FLAG_BYTE, st, 1'b0);
            push_word(1'b1, sfr_pkg::REPLY_ADDR, st, 1'b0);
            push_word(1'b1, ctrl, st, 1'b0);
            push_word(1'b1, sfr_pkg::REPLY_ADDR ^ ctrl, st, 1'b0);
            push_word(1'b1, sfr_pkg::FLAG_BYTE, st, 1'b1);
            status_count[st]++;
            chunks_closed++;
            clear_frame_state();
        end
    endtask

    task automatic offer(input logic [7:0] b, input logic fin);
        tx_queue.push_back({b, fin});
        words_queued++;
    endtask

    // bytes given most significant first
    task automatic offer_hex(input logic [127:0] bytes, input int n);
        for (int i = 0; i < n; i++) offer(bytes[8*(n-1-i) +: 8], i == n - 1);
    endtask

    task automatic queue_frame(input t_flaw flaw, input int pay_len);
        logic [7:0] cl[$];
        logic [7:0] raw[$];
        logic [7:0] bcc;
        logic [7:0] x;
        int         keep;
        bcc = 8'h00;
        cl.push_back(sfr_pkg::FLAG_BYTE);
        cl.push_back(addr_cfg);
        cl.push_back($urandom_range(0, 1) ? sfr_pkg::SEQ0_BYTE : rand_byte());
        cl.push_back(rand_byte());
        for (int i = 0; i < pay_len; i++) begin
            x = rand_byte();
            bcc ^= x;
            cl.push_back(x);
        end
        cl.push_back(bcc);
        cl.push_back(sfr_pkg::FLAG_BYTE);
        case (flaw)
            F_ADDR: cl[1] = addr_cfg ^ 8'($urandom_range(1, 255));
            F_HEAD: cl[0] = sfr_pkg::FLAG_BYTE ^ 8'($urandom_range(1, 255));
            F_TAIL: cl[cl.size()-1] = sfr_pkg::FLAG_BYTE ^ 8'($urandom_range(1, 255));
            F_BCC:  cl[cl.size()-2] = bcc ^ 8'($urandom_range(1, 255));
            default: ;
        endcase
        for (int i = 0; i < cl.size(); i++) begin
            x = cl[i];
            if ((i == 0 || i == cl.size() - 1) && x == sfr_pkg::FLAG_BYTE) begin
                raw.push_back(x);
            end else if (x == sfr_pkg::FLAG_BYTE || x == sfr_pkg::ESC_BYTE) begin
                raw.push_back(sfr_pkg::ESC_BYTE);
                raw.push_back(x == sfr_pkg::FLAG_BYTE ? sfr_pkg::ESC_FLAG : sfr_pkg::ESC_ESC);
            end else begin
                // a needless escape in front of a plain byte leaves it as is
                if ($urandom_range(0, 15) == 0 && x != sfr_pkg::ESC_FLAG &&
                    x != sfr_pkg::ESC_ESC)
                    raw.push_back(sfr_pkg::ESC_BYTE);
                raw.push_back(x);
            end
        end
        if (flaw == F_TRUNC) begin
            keep = $urandom_range(1, raw.size() - 1);
            raw = raw[0:keep-1];
        end
        if (flaw == F_NOISE) begin
            raw.delete();
            repeat ($urandom_range(1, 20)) raw.push_back(rand_byte());
        end
        if (flaw == F_DANGLE) raw.push_back(sfr_pkg::ESC_BYTE);
        for (int i = 0; i < raw.size(); i++) offer(raw[i], i == raw.size() - 1);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        while (words_taken != words_queued || rx_out_words.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_address(input logic [7:0] a);
        wait_drained();
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= a;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        addr_cfg = a;
        @(negedge i_clk);
    endtask

    // sender
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            tx_wait = 0;
        end else begin
            if (i_valid && !o_stall) begin
                destuff_byte(i_rx_byte, i_chunk_end);
                words_taken++;
                tx_wait = draw_gap(tx_idle);
            end
            if (!(i_valid && o_stall)) begin
                if (tx_wait > 0) begin
                    tx_wait--;
                    i_valid <= 1'b0;
                end else if (tx_queue.size() != 0) begin
                    tx_next = tx_queue.pop_front();
                    i_valid     <= 1'b1;
                    i_rx_byte   <= tx_next.b;
                    i_chunk_end <= tx_next.fin;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: checks each word taken and draws its own stall
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            rx_wait = 0;
        end else begin
            if (o_valid && !i_stall) begin
                words_checked++;
                if (rx_out_words.size() == 0) begin
                    $display("%0t: unexpected word: kind %0d byte %02h status %0d last %0d",
                             $time, o_out_kind, o_out_byte, o_frame_status, o_last_out);
                    mismatches++;
                end else begin
                    rx_head = rx_out_words.pop_front();
                    if ({o_out_kind, o_out_byte, o_frame_status, o_last_out} !== rx_head) begin
                        $display("%0t: expected kind %0d byte %02h status %0d last %0d",
                                 $time, rx_head.kind, rx_head.data, rx_head.status,
                                 rx_head.last);
                        $display("%0t:   actual kind %0d byte %02h status %0d last %0d",
                                 $time, o_out_kind, o_out_byte, o_frame_status, o_last_out);
                        mismatches++;
                    end
                end
                rx_wait = draw_gap(rx_idle);
            end else if (rx_wait > 0) begin
                rx_wait--;
            end
            if (hold_given != hold_asked) begin
                hold_given++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= (rx_wait > 0);
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles == CYCLE_LIMIT) begin
            $display("%0t: timed out with %0d words still owed", $time, rx_out_words.size());
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        logic [7:0] addr_plan[PHASES];
        t_flaw      flaw;
        int         r;
        int         start;
        addr_plan[0] = 8'h00;
        addr_plan[1] = 8'hFF;
        addr_plan[2] = sfr_pkg::ESC_BYTE;
        addr_plan[3] = sfr_pkg::FLAG_BYTE;
        addr_plan[4] = 8'($urandom_range(0, 255));
        addr_plan[5] = sfr_pkg::ADDR_RESET;
        addr_cfg = sfr_pkg::ADDR_RESET;
        clear_frame_state();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed, reset address: accepted seq 0, bad address seq 1,
        // escapes with bad bcc2, short chunk ending on an escape
        offer_hex(128'h7E_03_00_FF_00_7E, 6);
        offer_hex(128'h7E_04_01_00_00_7E, 6);
        offer_hex(128'h7E_03_01_11_7D_5E_7D_5D_55_7E, 10);
        offer_hex(128'h00_7D, 2);
        wait_drained();

        for (int p = 0; p < PHASES; p++) begin
            set_address(addr_plan[p]);
            tx_idle = (p != 3) && (p == 0 || $urandom_range(0, 3) != 0);
            rx_idle = (p != 3) && (p == 0 || $urandom_range(0, 3) != 0);
            if (p == 1) begin
                // receiver holds off while a long frame backs up the block
                hold_asked++;
                queue_frame(F_NONE, 40);
            end
            start = words_queued;
            while (words_queued - start < PHASE_WORDS) begin
                r = $urandom_range(0, 99);
                if (r < 60) flaw = F_NONE;
                else if (r < 66) flaw = F_ADDR;
                else if (r < 72) flaw = F_HEAD;
                else if (r < 78) flaw = F_TAIL;
                else if (r < 84) flaw = F_BCC;
                else if (r < 90) flaw = F_TRUNC;
                else if (r < 95) flaw = F_NOISE;
                else flaw = F_DANGLE;
                queue_frame(flaw, $urandom_range(0, 7) == 0 ? $urandom_range(13, 40)
                                                            : $urandom_range(0, 12));
                if (p == 2 && words_queued - start > PHASE_WORDS / 2 && r < 5)
                    wait_drained();
            end
        end

        wait_drained();
        $display("tb: %0d raw bytes in %0d chunks, %0d output words checked",
                 words_taken, chunks_closed, words_checked);
        $display("tb: statuses accepted %0d, short %0d, flag %0d, address %0d, bcc2 %0d",
                 status_count[0], status_count[1], status_count[2], status_count[3],
                 status_count[4]);
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

[files.f]
hw/rtl/sfr_pkg.sv
hw/rtl/stuffed_frame_receiver.sv
test/tb.sv
